// ===== design/chtu_pkg.sv =====
// ----------------------------------------------------------------------------
// Coalesced hash table package
// Operation and result codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package chtu_pkg;

   localparam int KEY_BITS  = 31;
   localparam int DATA_BITS = 32;
   localparam int SLOT_BITS = 6;
   localparam int CFG_BITS  = 7;
   localparam int BIT_CNT_BITS = 5;

   typedef enum logic [1:0] {
      KIND_SEARCH = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RES_OK        = 2'd0,
      RES_NOT_FOUND = 2'd1,
      RES_EXISTS    = 2'd2,
      RES_FULL      = 2'd3
   } result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_WALK_END,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_HOME_RD,
      ST_HOME_CHK,
      ST_SPLICE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== design/coalesced_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// Coalesced hash table unit
// Hash table with internal chaining: search, insert and delete of keys, with
// state held in a key/link/free memory and a data memory.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Contents
// req      in         req_tvalid/req_tready     kind in tuser, key and value in tdata
// rsp      out        rsp_tvalid/rsp_tready     result code in tuser, slot and value in tdata
// csr      in         csr_valid/csr_ready       table size
//
// An item runs through the home slot division, a walk over the chain slots
// (up to SLOTS), a probe for a free slot (inserts only, up to the table size),
// and then the write back and the result.
// After reset a clearing pass over all SLOTS slots runs before the first item.
// One item is in work at a time; the next is taken once the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module coalesced_hash_table_unit
   import chtu_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // key[30:0], entry_value[62:31], zero
   input  wire logic [1:0]  req_tuser,   // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // slot_index[5:0], found_value[37:6], zero
   output logic [1:0]       rsp_tuser,   // result_code[1:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_wdata    // table_size[6:0]
);

   localparam int IDX = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW  = $clog2(SLOTS + 1);
   localparam int MW  = KEY_BITS + IDX + 1;

   logic [MW-1:0]        meta_mem [SLOTS];
   logic [DATA_BITS-1:0] data_mem [SLOTS];
   logic [MW-1:0]        meta_q;
   logic [DATA_BITS-1:0] data_q;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [DATA_BITS-1:0] val_ff, val_in;
   logic [CFG_BITS-1:0]  tsize_ff;
   logic [NW-1:0]        n_ff, n_in, rem_ff, rem_in, cnt_ff, cnt_in;
   logic [BIT_CNT_BITS-1:0] bit_ff, bit_in;
   logic [IDX-1:0] cur_ff, cur_in, pos_ff, pos_in, plink_ff, plink_in;
   logic [IDX-1:0] home_ff, home_in, old_ff, old_in, clr_ff, clr_in;
   logic           hit_ff, hit_in, hasf_ff, hasf_in;
   result_type     code_ff, code_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [DATA_BITS-1:0] outv_ff, outv_in;

   logic [IDX-1:0]       rd_addr, wr_addr;
   logic                 wr_en, wr_den;
   logic [MW-1:0]        wr_meta;
   logic [KEY_BITS-1:0]  mq_key;
   logic [IDX-1:0]       mq_link;
   logic                 mq_free, mq_match;
   logic [NW:0]          div_sh;
   logic [NW-1:0]        eff_n;

   assign mq_key   = meta_q[MW-1 -: KEY_BITS];
   assign mq_link  = meta_q[IDX:1];
   assign mq_free  = meta_q[0];
   assign mq_match = !mq_free && (mq_key == key_ff);
   assign div_sh   = {rem_ff, key_ff[bit_ff]};

   always_comb begin
      if (tsize_ff == '0) begin
         eff_n = NW'(1);
      end else if (32'(tsize_ff) > 32'(SLOTS)) begin
         eff_n = NW'(SLOTS);
      end else begin
         eff_n = NW'(tsize_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         meta_mem[wr_addr] <= wr_meta;
      end
      if (wr_den) begin
         data_mem[wr_addr] <= val_ff;
      end
      meta_q <= meta_mem[rd_addr];
      data_q <= data_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         tsize_ff <= CFG_BITS'(64);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_valid && csr_ready) begin
            tsize_ff <= csr_wdata;
         end
      end
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      val_ff   <= val_in;
      n_ff     <= n_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      bit_ff   <= bit_in;
      cur_ff   <= cur_in;
      pos_ff   <= pos_in;
      plink_ff <= plink_in;
      home_ff  <= home_in;
      old_ff   <= old_in;
      hit_ff   <= hit_in;
      hasf_ff  <= hasf_in;
      code_ff  <= code_in;
      slot_ff  <= slot_in;
      outv_ff  <= outv_in;
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      n_in     = n_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      cur_in   = cur_ff;
      pos_in   = pos_ff;
      plink_in = plink_ff;
      home_in  = home_ff;
      old_in   = old_ff;
      hit_in   = hit_ff;
      hasf_in  = hasf_ff;
      code_in  = code_ff;
      slot_in  = slot_ff;
      outv_in  = outv_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = kind_type'(req_tuser);
               key_in  = req_tdata[30:0];
               val_in  = req_tdata[62:31];
               n_in    = eff_n;
               rem_in  = '0;
               bit_in  = BIT_CNT_BITS'(KEY_BITS - 1);
               code_in = RES_NOT_FOUND;
               slot_in = '0;
               outv_in = '0;
               if (kind_type'(req_tuser) == KIND_UNUSED) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_sh >= {1'b0, n_ff}) begin
               rem_in = NW'(div_sh - {1'b0, n_ff});
            end else begin
               rem_in = NW'(div_sh);
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               home_in  = IDX'(rem_in);
               cur_in   = IDX'(rem_in);
               cnt_in   = '0;
               hit_in   = 1'b0;
               hasf_in  = 1'b0;
               pos_in   = '0;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CHK;
         end
         ST_WALK_CHK: begin
            cnt_in = cnt_ff + 1'b1;
            if (mq_free) begin
               hasf_in  = 1'b1;
               pos_in   = cur_ff;
               plink_in = mq_link;
            end
            if (mq_match) begin
               hit_in   = 1'b1;
               pos_in   = cur_ff;
               plink_in = mq_link;
               outv_in  = data_q;
               state_in = ST_WALK_END;
            end else if (mq_link == cur_ff || 32'(mq_link) >= 32'(SLOTS)
                         || 32'(cnt_ff) + 32'd1 >= 32'(SLOTS)) begin
               state_in = ST_WALK_END;
            end else begin
               cur_in   = mq_link;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_END: begin
            state_in = ST_RESP;
            if (kind_ff != KIND_SEARCH) begin
               outv_in = '0;
            end
            if (hit_ff) begin
               slot_in = SLOT_BITS'(32'(pos_ff));
               code_in = (kind_ff == KIND_INSERT) ? RES_EXISTS : RES_OK;
            end else if (kind_ff == KIND_INSERT && hasf_ff) begin
               slot_in = SLOT_BITS'(32'(pos_ff));
               code_in = RES_OK;
            end else if (kind_ff == KIND_INSERT) begin
               cur_in   = home_ff;
               cnt_in   = '0;
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            if (mq_free) begin
               state_in = ST_HOME_RD;
            end else if (32'(cnt_ff) + 32'd1 >= 32'(n_ff)) begin
               code_in  = RES_FULL;
               slot_in  = '0;
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (32'(cur_ff) + 32'd1 == 32'(n_ff)) begin
                  cur_in = '0;
               end else begin
                  cur_in = cur_ff + 1'b1;
               end
               state_in = ST_PROBE_RD;
            end
         end
         ST_HOME_RD: begin
            state_in = ST_HOME_CHK;
         end
         ST_HOME_CHK: begin
            old_in   = mq_link;
            state_in = ST_SPLICE;
         end
         ST_SPLICE: begin
            code_in  = RES_OK;
            slot_in  = SLOT_BITS'(32'(cur_ff));
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_addr = cur_ff;
      wr_en   = 1'b0;
      wr_den  = 1'b0;
      wr_addr = cur_ff;
      wr_meta = {key_ff, cur_ff, 1'b0};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_meta = {{KEY_BITS{1'b1}}, clr_ff, 1'b1};
         end
         ST_WALK_END: begin
            wr_addr = pos_ff;
            if (hit_ff && kind_ff == KIND_DELETE) begin
               wr_en   = 1'b1;
               wr_meta = {key_ff, plink_ff, 1'b1};
            end else if (!hit_ff && hasf_ff && kind_ff == KIND_INSERT) begin
               wr_en   = 1'b1;
               wr_den  = 1'b1;
               wr_meta = {key_ff, plink_ff, 1'b0};
            end
         end
         ST_HOME_RD: begin
            rd_addr = home_ff;
         end
         ST_HOME_CHK: begin
            wr_en   = 1'b1;
            wr_addr = home_ff;
            wr_meta = {mq_key, cur_ff, mq_free};
         end
         ST_SPLICE: begin
            wr_en   = 1'b1;
            wr_den  = 1'b1;
            wr_meta = {key_ff, (old_ff == home_ff) ? cur_ff : old_ff, 1'b0};
         end
         default: begin
            rd_addr = cur_ff;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {2'b00, outv_ff, slot_ff};
   assign rsp_tuser  = code_ff;
   assign csr_ready  = 1'b1;

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input ready while a result is pending");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("input taken during clearing pass");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> 32'(wr_addr) < 32'(SLOTS))
      else $error("memory write beyond table");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

endmodule

`default_nettype wire
